[rtl/mws_pkg.sv]
package mws_pkg;

  localparam int MAX_TEXT_DEF    = 4096;
  localparam int MAX_PATTERN_DEF = 256;
  localparam int ALPHABET_DEF    = 128;

  localparam int CH_W     = 7;
  localparam int CH_CODES = 128;
  localparam int START_W  = 12;
  localparam int LEN_W    = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_UPD,
    ST_TXT_UPD,
    ST_CHK,
    ST_LTXT,
    ST_LUPD
  } state_t;

endpackage

[rtl/min_window_substring_finder.sv]
// pattern character: busy for a table update; text character: busy for a table update and a check,
// plus a text read, a table update and a check for each character that leaves the window from the left
// (one shared table port); the result strobe on out_valid is registered from the final check after
// the last text character, or from its transfer when that character is dropped for lack of room
// one item at a time; the receiver cannot stall, each result stands for one cycle
// rst_n is synchronous: control state and the count table valid bits clear at once
module min_window_substring_finder #(
  parameter int MAX_TEXT    = mws_pkg::MAX_TEXT_DEF,
  parameter int MAX_PATTERN = mws_pkg::MAX_PATTERN_DEF,
  parameter int ALPHABET    = mws_pkg::ALPHABET_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [mws_pkg::CH_W-1:0]     in_ch,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [mws_pkg::START_W-1:0]  out_start_res,
  output logic [mws_pkg::LEN_W-1:0]    out_length,
  output logic                         out_overflow
);

  import mws_pkg::*;

  localparam int CW  = $clog2(ALPHABET);
  localparam int TW  = $clog2(MAX_TEXT);
  localparam int RW  = $clog2(MAX_TEXT + 1);
  localparam int PW  = $clog2(MAX_PATTERN + 1);
  localparam int XW  = (PW > RW) ? PW : RW;
  localparam int TBW = PW + RW;

  typedef logic [CW-1:0] fold_tab_t [CH_CODES];

  function automatic fold_tab_t make_fold();
    fold_tab_t t;
    for (int i = 0; i < CH_CODES; i++) begin
      t[i] = CW'(i % ALPHABET);
    end
    return t;
  endfunction

  localparam fold_tab_t FOLD = make_fold();

  state_t state_r, state_nxt;

  logic [CW-1:0]       code_r, code_nxt;
  logic                last_r, last_nxt;
  logic [PW-1:0]       pat_len_r, pat_len_nxt;
  logic [PW-1:0]       matched_r, matched_nxt;
  logic [RW-1:0]       left_r, left_nxt;
  logic [RW-1:0]       right_r, right_nxt;
  logic [TW-1:0]       best_start_r, best_start_nxt;
  logic [RW-1:0]       best_len_r, best_len_nxt;
  logic                ovf_r, ovf_nxt;
  logic [ALPHABET-1:0] valid_r, valid_nxt;
  logic                tab_vld_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic          accept;
  logic          pat_full;
  logic          txt_full;
  logic          shrink;
  logic [CW-1:0] in_code;

  logic           tab_we;
  logic [CW-1:0]  tab_waddr;
  logic [TBW-1:0] tab_wdata;
  logic [CW-1:0]  tab_raddr;
  logic [TBW-1:0] tab_rdata;
  logic [PW-1:0]  need;
  logic [RW-1:0]  win;
  logic [XW-1:0]  need_x;
  logic [XW-1:0]  win_x;

  logic           txt_we;
  logic [CW-1:0]  txt_rdata;
  logic [RW-1:0]  win_len;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_code  = FOLD[in_ch];
  assign pat_full = (pat_len_r >= PW'(MAX_PATTERN));
  assign txt_full = (right_r >= RW'(MAX_TEXT));
  assign shrink   = (pat_len_r != '0) && (matched_r >= pat_len_r) && (left_r < right_r);
  assign win_len  = right_r - left_r;

  assign need   = tab_vld_r ? tab_rdata[TBW-1:RW] : '0;
  assign win    = tab_vld_r ? tab_rdata[RW-1:0] : '0;
  assign need_x = XW'(need);
  assign win_x  = XW'(win);

  assign txt_we = accept && in_kind && !txt_full;

  mws_ram #(
    .WIDTH (TBW),
    .DEPTH (ALPHABET)
  ) u_count_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  mws_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (right_r[TW-1:0]),
    .wdata (in_code),
    .raddr (left_r[TW-1:0]),
    .rdata (txt_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            if (!pat_full) state_nxt = ST_PAT_UPD;
          end else if (!txt_full) begin
            state_nxt = ST_TXT_UPD;
          end
        end
      end
      ST_PAT_UPD: state_nxt = ST_IDLE;
      ST_TXT_UPD: state_nxt = ST_CHK;
      ST_CHK: begin
        if (shrink) state_nxt = ST_LTXT;
        else        state_nxt = ST_IDLE;
      end
      ST_LTXT:  state_nxt = ST_LUPD;
      ST_LUPD:  state_nxt = ST_CHK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic clr;
    logic emit;
    logic [PW-1:0] need_w;
    logic [RW-1:0] win_w;

    clr    = 1'b0;
    emit   = 1'b0;
    need_w = need;
    win_w  = win;

    code_nxt       = code_r;
    last_nxt       = last_r;
    pat_len_nxt    = pat_len_r;
    matched_nxt    = matched_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    ovf_nxt        = ovf_r;

    tab_we    = 1'b0;
    tab_waddr = code_r;
    tab_raddr = code_r;

    unique case (state_r)
      ST_IDLE: begin
        tab_raddr = in_code;
        if (accept) begin
          code_nxt = in_code;
          last_nxt = in_last;
          if (in_kind && txt_full) begin
            ovf_nxt = 1'b1;
            if (in_last) begin
              emit = 1'b1;
              clr  = 1'b1;
            end
          end else if (in_kind) begin
            right_nxt = right_r + RW'(1);
          end
        end
      end
      ST_PAT_UPD: begin
        if (win_x > need_x) matched_nxt = matched_r + PW'(1);
        need_w      = need + PW'(1);
        pat_len_nxt = pat_len_r + PW'(1);
        tab_we      = 1'b1;
      end
      ST_TXT_UPD: begin
        if (win_x < need_x) matched_nxt = matched_r + PW'(1);
        win_w  = win + RW'(1);
        tab_we = 1'b1;
      end
      ST_CHK: begin
        if (shrink) begin
          if (best_len_r == '0 || win_len < best_len_r) begin
            best_len_nxt   = win_len;
            best_start_nxt = left_r[TW-1:0];
          end
        end else if (last_r) begin
          emit = 1'b1;
          clr  = 1'b1;
        end
      end
      ST_LTXT: begin
        tab_raddr = txt_rdata;
        code_nxt  = txt_rdata;
      end
      ST_LUPD: begin
        if (win != '0) begin
          if (win_x <= need_x) matched_nxt = matched_r - PW'(1);
          win_w = win - RW'(1);
        end
        tab_we   = 1'b1;
        left_nxt = left_r + RW'(1);
      end
      default: begin
        tab_we = 1'b0;
      end
    endcase

    tab_wdata = {need_w, win_w};

    valid_nxt = valid_r;
    if (tab_we) valid_nxt[tab_waddr] = 1'b1;

    out_valid_nxt = emit;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    if (emit) begin
      out_found_nxt = (best_len_r != '0);
      out_start_nxt = (best_len_r != '0) ? START_W'(best_start_r) : '0;
      out_len_nxt   = LEN_W'(best_len_r);
      out_ovf_nxt   = ovf_nxt;
    end

    if (clr) begin
      pat_len_nxt    = '0;
      matched_nxt    = '0;
      left_nxt       = '0;
      right_nxt      = '0;
      best_start_nxt = '0;
      best_len_nxt   = '0;
      ovf_nxt        = 1'b0;
      valid_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pat_len_r    <= '0;
      matched_r    <= '0;
      left_r       <= '0;
      right_r      <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      ovf_r        <= 1'b0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pat_len_r    <= pat_len_nxt;
      matched_r    <= matched_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      ovf_r        <= ovf_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    last_r      <= last_nxt;
    tab_vld_r   <= valid_r[tab_raddr];
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_start_res = out_start_r;
  assign out_length    = out_len_r;
  assign out_overflow  = out_ovf_r;

endmodule

[rtl/mws_ram.sv]
module mws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mws_checker.sv]
module mws_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_kind,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_found,
  input logic [mws_pkg::START_W-1:0] out_start_res,
  input logic [mws_pkg::LEN_W-1:0]   out_length
);

  // a miss reports an empty window at index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_length == '0 && out_start_res == '0)
    else $error("not-found result with nonzero window");

  a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_length != '0)
    else $error("found result with zero length");

  // a result only ever closes a job, so the block is idle while it stands
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  a_pat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_kind |=> !out_valid)
    else $error("result after pattern transfer");

  a_txt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind && !in_last |=> !out_valid)
    else $error("result after non-final text transfer");

endmodule

bind min_window_substring_finder mws_checker u_mws_checker (.*);
